// ===== hdl/rw3d_pkg.sv =====
package rw3d_pkg;

    localparam int COORD_WIDTH_DEF = 40;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int RAND_BITS_DEF   = 16;

    localparam int PHASE_W      = 32;
    localparam int CORDIC_ITERS = 16;
    localparam int CORDIC_IW    = 4;
    localparam int CORDIC_XY_W  = 32;
    localparam int CORDIC_Z_W   = 33;
    localparam int MUL_W        = 33;

    localparam logic signed [CORDIC_XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    localparam logic [1:0] MUL_ST_CP = 2'd0;
    localparam logic [1:0] MUL_ST_SP = 2'd1;
    localparam logic [1:0] MUL_SQ    = 2'd2;

    localparam logic [1:0] ADD_SRC_LAT = 2'd0;
    localparam logic [1:0] ADD_SRC_XY  = 2'd1;
    localparam logic [1:0] ADD_SRC_Z   = 2'd2;

    localparam logic MODE_LATTICE   = 1'b0;
    localparam logic MODE_CONTINUUM = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LAT,
        ST_COR_T,
        ST_WAIT_T,
        ST_COR_P,
        ST_WAIT_P,
        ST_MUL_X,
        ST_ADD_X,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_ADD_Z,
        ST_SQ,
        ST_SQ_LAST,
        ST_ROOT,
        ST_WAIT_ROOT,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic       cor_start;
        logic       cor_sel_phi;
        logic [1:0] mul_sel;
        logic       add_en;
        logic [1:0] add_axis;
        logic [1:0] add_src;
        logic       sqrt_start;
        logic       out_load;
    } ctrl_t;

    // Arctangent of 2^-i in binary phase units (2^32 is one turn).
    function automatic logic [CORDIC_Z_W-1:0] atan_turn(input logic [CORDIC_IW-1:0] idx);
        logic [CORDIC_Z_W-1:0] val;
        case (idx)
            4'd0:    val = 33'd536870912;
            4'd1:    val = 33'd316933406;
            4'd2:    val = 33'd167458907;
            4'd3:    val = 33'd85004756;
            4'd4:    val = 33'd42667331;
            4'd5:    val = 33'd21354465;
            4'd6:    val = 33'd10679838;
            4'd7:    val = 33'd5340245;
            4'd8:    val = 33'd2670163;
            4'd9:    val = 33'd1335087;
            4'd10:   val = 33'd667544;
            4'd11:   val = 33'd333772;
            4'd12:   val = 33'd166886;
            4'd13:   val = 33'd83443;
            4'd14:   val = 33'd41722;
            4'd15:   val = 33'd20861;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/rw3d_mul.sv =====
module rw3d_mul import rw3d_pkg::*; (
    input  logic                        aclk,
    input  logic signed [MUL_W-1:0]     op_a,
    input  logic signed [MUL_W-1:0]     op_b,
    output logic signed [2*MUL_W-1:0]   prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

// ===== hdl/rw3d_cordic.sv =====
module rw3d_cordic import rw3d_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [PHASE_W-1:0]             phase,
    output logic                           done_reg,
    output logic signed [CORDIC_XY_W-1:0]  sin_out,
    output logic signed [CORDIC_XY_W-1:0]  cos_out
);

    logic                          busy_reg;
    logic [CORDIC_IW-1:0]          iter_reg;
    logic                          flip_reg;
    logic signed [CORDIC_XY_W-1:0] x_reg, y_reg;
    logic signed [CORDIC_XY_W-1:0] x_next, y_next;
    logic signed [CORDIC_Z_W-1:0]  z_reg, z_next;
    logic signed [CORDIC_XY_W-1:0] dx, dy;
    logic signed [CORDIC_Z_W-1:0]  atan_val;
    logic                          flip_in;
    logic [PHASE_W-1:0]            phase_adj;

    // A phase in the left half-plane is turned by half a turn; the results are negated.
    assign flip_in   = phase[PHASE_W-1] ^ phase[PHASE_W-2];
    assign phase_adj = {phase[PHASE_W-1] ^ flip_in, phase[PHASE_W-2:0]};

    assign dx       = y_reg >>> iter_reg;
    assign dy       = x_reg >>> iter_reg;
    assign atan_val = $signed(atan_turn(iter_reg));

    always_comb begin
        if (!z_reg[CORDIC_Z_W-1]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_val;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == CORDIC_IW'(CORDIC_ITERS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({phase_adj[PHASE_W-1], phase_adj});
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign sin_out = flip_reg ? -y_reg : y_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;

endmodule

// ===== hdl/rw3d_sqrt.sv =====
module rw3d_sqrt import rw3d_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [2*COORD_WIDTH-1:0]   radicand,
    output logic                       done_reg,
    output logic [COORD_WIDTH-1:0]     root_reg
);

    localparam int RAD_W = 2 * COORD_WIDTH;
    localparam int REM_W = COORD_WIDTH + 2;
    localparam int CNT_W = $clog2(COORD_WIDTH + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_sh, trial;
    logic             fits;

    // Restoring square root, one result bit per cycle from the top.
    assign rem_sh = {rem_reg[COORD_WIDTH-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[COORD_WIDTH-2:0], fits};
        end
    end

endmodule

// ===== hdl/random_walk_3d_step.sv =====
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser walk_start, tdata rand_a, rand_b
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata pos_x, pos_y, pos_z, distance
// cfg       in         cfg_we                        cfg_wdata walk_mode
//
// The work on an item is the two 16-step CORDIC runs (continuum mode only), nine passes
// through the shared multiplier for the squared norm, and the one-bit-per-cycle square
// root.
// Reset clears the position, the walk mode and all handshake state.
// The result waits in an output register, so a stalled m_axis holds only the final
// load of the next item.
module random_walk_3d_step import rw3d_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int RAND_BITS   = RAND_BITS_DEF,
    localparam int IN_TDATA_W  = ((2 * RAND_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // rand_a, rand_b
    input  logic                    s_axis_tuser,   // walk_start
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata    // pos_x, pos_y, pos_z, distance
);

    localparam int HALF_W = (COORD_WIDTH + 1) / 2;
    localparam int ACC_W  = 2 * COORD_WIDTH;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = COORD_WIDTH + 1;

    localparam logic signed [SUM_W-1:0] LAT_STEP = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND_XY = PROD_W'(1) << (59 - FRAC_BITS);
    localparam logic signed [CORDIC_XY_W:0] RND_Z = (CORDIC_XY_W + 1)'(1) << (29 - FRAC_BITS);
    localparam logic signed [COORD_WIDTH-1:0] POS_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] POS_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic                 s_accept;
    logic                 walk_mode_reg;
    logic [RAND_BITS-1:0] rand_a_reg, rand_b_reg;

    logic signed [COORD_WIDTH-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [COORD_WIDTH-1:0] pos_x_next, pos_y_next, pos_z_next;

    logic                          cor_done;
    logic signed [CORDIC_XY_W-1:0] cor_sin, cor_cos;
    logic signed [CORDIC_XY_W-1:0] st_reg, ct_reg, sp_reg, cp_reg;
    logic [PHASE_W-1:0]            theta_phase, phi_phase;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic [RAND_BITS+1:0]           lat_prod;
    logic [1:0]                     lat_axis;
    logic signed [COORD_WIDTH-1:0]  add_a;
    logic signed [SUM_W-1:0]        add_d, add_sum;
    logic signed [COORD_WIDTH-1:0]  add_res;
    logic signed [PROD_W-1:0]       rnd_xy;
    logic signed [CORDIC_XY_W:0]    rnd_z;

    logic [1:0]                    sq_coord_reg, sq_part_reg, sq_part_d_reg;
    logic                          sq_pend_reg;
    logic [ACC_W-1:0]              acc_reg, sq_prod_ext, sq_term;
    logic signed [COORD_WIDTH-1:0] sq_pos;
    logic [COORD_WIDTH-1:0]        sq_mag;
    logic signed [MUL_W-1:0]       lo_op, hi_op;

    logic                   sqrt_done;
    logic [COORD_WIDTH-1:0] sqrt_root;

    logic                          m_valid_reg;
    logic [COORD_WIDTH-1:0]        out_x_reg, out_y_reg, out_z_reg, out_dist_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_mode_reg <= MODE_LATTICE;
        end else if (cfg_we) begin
            walk_mode_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rand_a_reg <= s_axis_tdata[RAND_BITS-1:0];
            rand_b_reg <= s_axis_tdata[2*RAND_BITS-1:RAND_BITS];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (walk_mode_reg == MODE_CONTINUUM) ? ST_COR_T : ST_LAT;
                end
            end
            ST_LAT:    state_next = ST_SQ;
            ST_COR_T:  state_next = ST_WAIT_T;
            ST_WAIT_T: begin
                if (cor_done) begin
                    state_next = ST_COR_P;
                end
            end
            ST_COR_P:  state_next = ST_WAIT_P;
            ST_WAIT_P: begin
                if (cor_done) begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:  state_next = ST_ADD_X;
            ST_ADD_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_ADD_Y;
            ST_ADD_Y:  state_next = ST_ADD_Z;
            ST_ADD_Z:  state_next = ST_SQ;
            ST_SQ: begin
                if (sq_coord_reg == AXIS_Z && sq_part_reg == PART_HH) begin
                    state_next = ST_SQ_LAST;
                end
            end
            ST_SQ_LAST: state_next = ST_ROOT;
            ST_ROOT:    state_next = ST_WAIT_ROOT;
            ST_WAIT_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        ctrl.mul_sel = MUL_SQ;
        case (state_reg)
            ST_LAT: begin
                ctrl.add_en   = 1'b1;
                ctrl.add_axis = lat_axis;
                ctrl.add_src  = ADD_SRC_LAT;
            end
            ST_COR_T: ctrl.cor_start = 1'b1;
            ST_COR_P: begin
                ctrl.cor_start   = 1'b1;
                ctrl.cor_sel_phi = 1'b1;
            end
            ST_MUL_X: ctrl.mul_sel = MUL_ST_CP;
            ST_ADD_X: begin
                ctrl.add_en   = 1'b1;
                ctrl.add_axis = AXIS_X;
                ctrl.add_src  = ADD_SRC_XY;
            end
            ST_MUL_Y: ctrl.mul_sel = MUL_ST_SP;
            ST_ADD_Y: begin
                ctrl.add_en   = 1'b1;
                ctrl.add_axis = AXIS_Y;
                ctrl.add_src  = ADD_SRC_XY;
            end
            ST_ADD_Z: begin
                ctrl.add_en   = 1'b1;
                ctrl.add_axis = AXIS_Z;
                ctrl.add_src  = ADD_SRC_Z;
            end
            ST_ROOT: ctrl.sqrt_start = 1'b1;
            ST_LOAD: ctrl.out_load = !m_valid_reg || m_axis_tready;
            default: ctrl = ctrl;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign theta_phase = PHASE_W'(rand_a_reg) << (PHASE_W - 1 - RAND_BITS);
    assign phi_phase   = PHASE_W'(rand_b_reg) << (PHASE_W - RAND_BITS);

    rw3d_cordic u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.cor_start),
        .phase    (ctrl.cor_sel_phi ? phi_phase : theta_phase),
        .done_reg (cor_done),
        .sin_out  (cor_sin),
        .cos_out  (cor_cos)
    );

    always_ff @(posedge aclk) begin
        if (cor_done && state_reg == ST_WAIT_T) begin
            st_reg <= cor_sin;
            ct_reg <= cor_cos;
        end
        if (cor_done && state_reg == ST_WAIT_P) begin
            sp_reg <= cor_sin;
            cp_reg <= cor_cos;
        end
    end

    always_comb begin
        case (sq_coord_reg)
            AXIS_X:  sq_pos = pos_x_reg;
            AXIS_Y:  sq_pos = pos_y_reg;
            default: sq_pos = pos_z_reg;
        endcase
    end

    assign sq_mag = sq_pos[COORD_WIDTH-1] ? (~sq_pos + 1'b1) : sq_pos;
    assign lo_op  = $signed({{(MUL_W-HALF_W){1'b0}}, sq_mag[HALF_W-1:0]});
    assign hi_op  = $signed({{(MUL_W-COORD_WIDTH+HALF_W){1'b0}},
                             sq_mag[COORD_WIDTH-1:HALF_W]});

    always_comb begin
        case (ctrl.mul_sel)
            MUL_ST_CP: begin
                mul_a = MUL_W'(st_reg);
                mul_b = MUL_W'(cp_reg);
            end
            MUL_ST_SP: begin
                mul_a = MUL_W'(st_reg);
                mul_b = MUL_W'(sp_reg);
            end
            default: begin
                case (sq_part_reg)
                    PART_LL: begin
                        mul_a = lo_op;
                        mul_b = lo_op;
                    end
                    PART_HL: begin
                        mul_a = hi_op;
                        mul_b = lo_op;
                    end
                    default: begin
                        mul_a = hi_op;
                        mul_b = hi_op;
                    end
                endcase
            end
        endcase
    end

    rw3d_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod)
    );

    // The cross term mh*ml appears twice in the square, hence one extra bit of shift.
    assign sq_prod_ext = ACC_W'(prod[2*HALF_W-1:0]);

    always_comb begin
        case (sq_part_d_reg)
            PART_LL: sq_term = sq_prod_ext;
            PART_HL: sq_term = sq_prod_ext << (HALF_W + 1);
            default: sq_term = sq_prod_ext << (2 * HALF_W);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_coord_reg  <= AXIS_X;
            sq_part_reg   <= PART_LL;
            sq_part_d_reg <= PART_LL;
            sq_pend_reg   <= 1'b0;
        end else begin
            sq_part_d_reg <= sq_part_reg;
            sq_pend_reg   <= (state_reg == ST_SQ);
            if (state_reg == ST_SQ) begin
                if (sq_part_reg == PART_HH) begin
                    sq_part_reg  <= PART_LL;
                    sq_coord_reg <= sq_coord_reg + 1'b1;
                end else begin
                    sq_part_reg <= sq_part_reg + 1'b1;
                end
            end else begin
                sq_part_reg  <= PART_LL;
                sq_coord_reg <= AXIS_X;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_pend_reg) begin
            acc_reg <= acc_reg + sq_term;
        end else begin
            acc_reg <= '0;
        end
    end

    assign lat_prod = {2'b00, rand_a_reg} + {1'b0, rand_a_reg, 1'b0};
    assign lat_axis = lat_prod[RAND_BITS+1:RAND_BITS];
    assign rnd_xy   = prod + RND_XY;
    assign rnd_z    = {ct_reg[CORDIC_XY_W-1], ct_reg} + RND_Z;

    always_comb begin
        case (ctrl.add_axis)
            AXIS_X:  add_a = pos_x_reg;
            AXIS_Y:  add_a = pos_y_reg;
            default: add_a = pos_z_reg;
        endcase
        case (ctrl.add_src)
            ADD_SRC_LAT: add_d = rand_b_reg[RAND_BITS-1] ? LAT_STEP : -LAT_STEP;
            ADD_SRC_XY:  add_d = SUM_W'(rnd_xy >>> (60 - FRAC_BITS));
            default:     add_d = SUM_W'(rnd_z >>> (30 - FRAC_BITS));
        endcase
    end

    assign add_sum = {add_a[COORD_WIDTH-1], add_a} + add_d;

    always_comb begin
        if (add_sum[SUM_W-1] != add_sum[SUM_W-2]) begin
            add_res = add_sum[SUM_W-1] ? POS_MIN : POS_MAX;
        end else begin
            add_res = add_sum[COORD_WIDTH-1:0];
        end
    end

    always_comb begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        pos_z_next = pos_z_reg;
        if (s_accept && s_axis_tuser) begin
            pos_x_next = '0;
            pos_y_next = '0;
            pos_z_next = '0;
        end else if (ctrl.add_en) begin
            case (ctrl.add_axis)
                AXIS_X:  pos_x_next = add_res;
                AXIS_Y:  pos_y_next = add_res;
                default: pos_z_next = add_res;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
        end
    end

    rw3d_sqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.sqrt_start),
        .radicand (acc_reg),
        .done_reg (sqrt_done),
        .root_reg (sqrt_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_x_reg    <= pos_x_reg;
            out_y_reg    <= pos_y_reg;
            out_z_reg    <= pos_z_reg;
            out_dist_reg <= sqrt_root;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_dist_reg, out_z_reg, out_y_reg, out_x_reg});

endmodule

// ===== bench/tb_random_walk_3d_step.sv =====
module tb_random_walk_3d_step;
    import rw3d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW     = COORD_WIDTH_DEF;
    localparam int FB     = FRAC_BITS_DEF;
    localparam int RB     = RAND_BITS_DEF;
    localparam int IN_W   = ((2 * RB + 7) / 8) * 8;
    localparam int OUT_W  = ((4 * CW + 7) / 8) * 8;
    localparam int N_DIR  = 19;
    localparam int SEG_ITEMS = 158;
    localparam int TAIL_CYCLES = 120;
    localparam int MAX_REPORTS = 10;

    localparam longint ATAN_TURNS [0:15] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    localparam logic [RB-1:0] CORNERS [0:9] = '{
        16'd0, 16'd65535, 16'd21845, 16'd21846, 16'd43690,
        16'd43691, 16'd32767, 16'd32768, 16'd16384, 16'd49152
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [CW-1:0]        distance;
    } walk_result_t;

    typedef struct packed {
        logic signed [63:0] sn;
        logic signed [63:0] cs;
    } sincos_t;

    typedef struct packed {
        logic          mode;
        logic          start;
        logic [RB-1:0] a;
        logic [RB-1:0] b;
        logic          typed;
        walk_result_t  res;
    } step_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // rand_a, rand_b
    logic              s_axis_tuser = 1'b0; // walk_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // pos_x, pos_y, pos_z, distance

    random_walk_3d_step dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    longint       pos_x_model;
    longint       pos_y_model;
    longint       pos_z_model;
    logic         walk_mode = MODE_LATTICE;
    walk_result_t pending_positions [$];
    step_row_t    directed_rows [0:N_DIR-1];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int unexpected = 0;
    int results_seen = 0;
    int lattice_items = 0;
    int continuum_items = 0;
    int walk_starts = 0;

    function automatic longint sat_coord(input longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint round_down_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic sincos_t cordic_sincos(input logic [31:0] phase_in);
        sincos_t            res;
        logic [31:0]        phase;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic               flip;
        phase = phase_in;
        flip = 1'b0;
        if (phase >= 32'h4000_0000 && phase < 32'hC000_0000) begin
            phase = phase - 32'h8000_0000;
            flip = 1'b1;
        end
        z = {{32{phase[31]}}, phase};
        x = 64'(CORDIC_GAIN);
        y = '0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        res.sn = y;
        res.cs = x;
        return res;
    endfunction

    function automatic logic [CW-1:0] norm_of_position(input longint x, input longint y,
                                                       input longint z);
        logic [127:0] acc;
        logic [127:0] wide;
        logic [63:0]  mag;
        logic [63:0]  root;
        logic [63:0]  cand;
        longint       comps [0:2];
        comps[0] = x;
        comps[1] = y;
        comps[2] = z;
        acc = '0;
        for (int k = 0; k < 3; k++) begin
            mag = (comps[k] < 0) ? -comps[k] : comps[k];
            wide = 128'(mag);
            acc = acc + wide * wide;
        end
        root = '0;
        for (int bitpos = 63; bitpos >= 0; bitpos--) begin
            cand = root | (64'd1 << bitpos);
            wide = 128'(cand);
            if (wide * wide <= acc) root = cand;
        end
        if (root > ((64'd1 << CW) - 1)) root = (64'd1 << CW) - 1;
        return root[CW-1:0];
    endfunction

    function automatic walk_result_t step_walk(input logic start, input logic [RB-1:0] a,
                                               input logic [RB-1:0] b);
        walk_result_t r;
        sincos_t      th;
        sincos_t      ph;
        longint       dlt;
        logic [RB+1:0] a3;
        if (start) begin
            pos_x_model = 0;
            pos_y_model = 0;
            pos_z_model = 0;
        end
        if (walk_mode == MODE_LATTICE) begin
            a3 = (RB + 2)'(3 * int'(a));
            dlt = (b < (1 << (RB - 1))) ? -(64'sd1 <<< FB) : (64'sd1 <<< FB);
            case (a3[RB+1:RB])
                AXIS_X:  pos_x_model = sat_coord(pos_x_model + dlt);
                AXIS_Y:  pos_y_model = sat_coord(pos_y_model + dlt);
                default: pos_z_model = sat_coord(pos_z_model + dlt);
            endcase
        end else begin
            th = cordic_sincos(32'(a) << (31 - RB));
            ph = cordic_sincos(32'(b) << (32 - RB));
            pos_x_model = sat_coord(pos_x_model + round_down_shift(th.sn * ph.cs, 60 - FB));
            pos_y_model = sat_coord(pos_y_model + round_down_shift(th.sn * ph.sn, 60 - FB));
            pos_z_model = sat_coord(pos_z_model + round_down_shift(th.cs, 30 - FB));
        end
        r.x = pos_x_model[CW-1:0];
        r.y = pos_y_model[CW-1:0];
        r.z = pos_z_model[CW-1:0];
        r.distance = norm_of_position(pos_x_model, pos_y_model, pos_z_model);
        return r;
    endfunction

    function automatic logic [RB-1:0] pick_fraction();
        if ($urandom_range(7) == 0) return CORNERS[$urandom_range(9)];
        return RB'($urandom_range((1 << RB) - 1));
    endfunction

    task automatic send_step(input logic start, input logic [RB-1:0] a, input logic [RB-1:0] b,
                             input logic typed, input walk_result_t typed_res);
        walk_result_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= IN_W'({b, a});
        do @(posedge aclk); while (!s_axis_tready);
        predicted = step_walk(start, a, b);
        pending_positions.push_back(typed ? typed_res : predicted);
        if (walk_mode == MODE_LATTICE) lattice_items++;
        else continuum_items++;
        if (start) walk_starts++;
    endtask

    task automatic wait_drained();
        while (pending_positions.size() != 0) @(posedge aclk);
    endtask

    task automatic set_walk_mode(input logic mode);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        walk_mode = mode;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        walk_result_t got;
        walk_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.x        = m_axis_tdata[CW-1:0];
            got.y        = m_axis_tdata[2*CW-1:CW];
            got.z        = m_axis_tdata[3*CW-1:2*CW];
            got.distance = m_axis_tdata[4*CW-1:3*CW];
            results_seen++;
            if (pending_positions.size() == 0) begin
                unexpected++;
                $display("Result with no item pending: x=%0d y=%0d z=%0d d=%0d",
                         got.x, got.y, got.z, got.distance);
            end else begin
                want = pending_positions.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d:", results_seen);
                        $display("  expected x=%0d y=%0d z=%0d d=%0d",
                                 want.x, want.y, want.z, want.distance);
                        $display("  actual   x=%0d y=%0d z=%0d d=%0d",
                                 got.x, got.y, got.z, got.distance);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("tb_random_walk_3d_step: FAIL");
        $finish;
    end

    initial begin
        walk_result_t none;
        int           leftover;
        none = '0;
        directed_rows = '{
            '{MODE_LATTICE, 1'b1, 16'd0, 16'd0, 1'b1,
              '{-40'sd65536, 40'sd0, 40'sd0, 40'd65536}},
            '{MODE_LATTICE, 1'b0, 16'd0, 16'd0, 1'b1,
              '{-40'sd131072, 40'sd0, 40'sd0, 40'd131072}},
            '{MODE_LATTICE, 1'b1, 16'd21845, 16'd32767, 1'b1,
              '{-40'sd65536, 40'sd0, 40'sd0, 40'd65536}},
            '{MODE_LATTICE, 1'b1, 16'd21846, 16'd32768, 1'b1,
              '{40'sd0, 40'sd65536, 40'sd0, 40'd65536}},
            '{MODE_LATTICE, 1'b1, 16'd43690, 16'd65535, 1'b1,
              '{40'sd0, 40'sd65536, 40'sd0, 40'd65536}},
            '{MODE_LATTICE, 1'b1, 16'd43691, 16'd0, 1'b1,
              '{40'sd0, 40'sd0, -40'sd65536, 40'd65536}},
            '{MODE_LATTICE, 1'b1, 16'd65535, 16'd65535, 1'b1,
              '{40'sd0, 40'sd0, 40'sd65536, 40'd65536}},
            '{MODE_LATTICE, 1'b0, 16'd65535, 16'd65535, 1'b1,
              '{40'sd0, 40'sd0, 40'sd131072, 40'd131072}},
            '{MODE_LATTICE, 1'b0, 16'd0, 16'd65535, 1'b0, none},
            '{MODE_CONTINUUM, 1'b1, 16'd0, 16'd0, 1'b0, none},
            '{MODE_CONTINUUM, 1'b0, 16'd65535, 16'd65535, 1'b0, none},
            '{MODE_CONTINUUM, 1'b1, 16'd32768, 16'd0, 1'b0, none},
            '{MODE_CONTINUUM, 1'b0, 16'd32768, 16'd16384, 1'b0, none},
            '{MODE_CONTINUUM, 1'b0, 16'd16384, 16'd32768, 1'b0, none},
            '{MODE_CONTINUUM, 1'b0, 16'd49152, 16'd49152, 1'b0, none},
            '{MODE_CONTINUUM, 1'b0, 16'd32767, 16'd32767, 1'b0, none},
            '{MODE_CONTINUUM, 1'b1, 16'd1, 16'd65535, 1'b0, none},
            '{MODE_LATTICE, 1'b1, 16'd32768, 16'd32768, 1'b1,
              '{40'sd0, 40'sd65536, 40'sd0, 40'd65536}},
            '{MODE_LATTICE, 1'b0, 16'd21845, 16'd1, 1'b0, none}
        };
        pos_x_model = 0;
        pos_y_model = 0;
        pos_z_model = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_walk_mode(MODE_LATTICE);
        for (int i = 0; i < N_DIR; i++) begin
            if (directed_rows[i].mode != walk_mode) set_walk_mode(directed_rows[i].mode);
            send_step(directed_rows[i].start, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].typed, directed_rows[i].res);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int m = 0; m < 2; m++) begin
                set_walk_mode((m == 0) ? MODE_CONTINUUM : MODE_LATTICE);
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    send_step(($urandom_range(24) == 0), pick_fraction(), pick_fraction(),
                              1'b0, none);
                end
            end
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        leftover = pending_positions.size();

        $display("Covered %0d lattice and %0d continuum steps, %0d new walks, both modes.",
                 lattice_items, continuum_items, walk_starts);
        $display("Checked %0d results: %0d mismatched, %0d unexpected, %0d missing.",
                 results_seen, mismatches, unexpected, leftover);
        if (mismatches == 0 && unexpected == 0 && leftover == 0) begin
            $display("tb_random_walk_3d_step: PASS");
        end else begin
            $display("tb_random_walk_3d_step: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/rw3d_pkg.sv
hdl/rw3d_mul.sv
hdl/rw3d_cordic.sv
hdl/rw3d_sqrt.sv
hdl/random_walk_3d_step.sv
bench/tb_random_walk_3d_step.sv
